/* design/twgt_pkg.sv */
// Shared types, constants and helpers for the twiddle gain tuner.
// Used by twgt_div and twiddle_gain_tuner; no dependencies.
package twgt_pkg;

  localparam int MAX_GAINS = 3;
  localparam int IDX_W     = 2;   // swept index / gain pointer
  localparam int PHASE_W   = 3;
  localparam int SUM_W     = 49;  // window sum of Q8.24 costs
  localparam int WL_W      = 16;
  localparam int CNT_W     = WL_W + 1;
  // a shortened window can still divide a long sum by 1
  localparam int AVG_W     = SUM_W - 8;
  localparam int GAIN_W    = 32;
  localparam int STEP_W    = 31;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_CNT_W = 6;   // holds SUM_W

  // phase codes
  localparam logic [PHASE_W-1:0] PH_BASE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PLUS  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WSKIP = 3'd2;
  localparam logic [PHASE_W-1:0] PH_MINUS = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RSKIP = 3'd4;

  // register indexes
  localparam logic [2:0] REG_NUM_PARAMS = 3'd0;
  localparam logic [2:0] REG_WIN_LEN    = 3'd1;
  localparam logic [2:0] REG_GAIN_0     = 3'd2;
  localparam logic [2:0] REG_GAIN_1     = 3'd3;
  localparam logic [2:0] REG_GAIN_2     = 3'd4;
  localparam logic [2:0] REG_STEP_0     = 3'd5;
  localparam logic [2:0] REG_STEP_1     = 3'd6;
  localparam logic [2:0] REG_STEP_2     = 3'd7;

  // 1.1 and 0.9 in Q16.16
  localparam logic signed [MUL_B_W-1:0] GROW_Q16   = 18'sd72090;
  localparam logic signed [MUL_B_W-1:0] SHRINK_Q16 = 18'sd58982;
  localparam logic [STEP_W-1:0]         STEP_MAX   = 31'h7FFF_FFFF;

  localparam logic [GAIN_W-1:0] GAIN_RST = 32'd0;
  localparam logic [STEP_W-1:0] STEP_RST = 31'd65536;

  function automatic logic [GAIN_W-1:0] sat_gain(input logic signed [GAIN_W+1:0] v);
    logic [GAIN_W-1:0] r;
    if (v > 34'sh0_7FFF_FFFF)
      r = 32'h7FFF_FFFF;
    else if (v < -34'sh0_8000_0000)
      r = 32'h8000_0000;
    else
      r = v[GAIN_W-1:0];
    return r;
  endfunction

endpackage

/* design/twgt_div.sv */
// Restoring divider, one quotient bit per cycle: window sum / window length.
// Depends on twgt_pkg.
module twgt_div import twgt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [WL_W-1:0]  divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [WL_W-1:0]      rem;
  logic [WL_W-1:0]      dvs;
  logic [SUM_W-1:0]     q;
  logic [WL_W:0]        trial;
  logic                 ge;
  logic [WL_W:0]        diff;

  always_comb begin
    trial = {rem, q[SUM_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(SUM_W);
        q   <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        q   <= {q[SUM_W-2:0], ge};
        rem <= ge ? diff[WL_W-1:0] : trial[WL_W-1:0];
        if (cnt == DIV_CNT_W'(1))
          done <= 1'b1;
      end
    end
  end

  assign quotient = q;

endmodule

/* design/twiddle_gain_tuner.sv */
// Twiddle (coordinate descent) tuner for up to three Q16.16 controller gains.
// An ordinary sample passes the two squaring states and the accumulate state;
// the sample that closes a window also waits on the bit-serial divider that
// forms the window average, then the compare and any step rescale through the
// one shared 32x18 multiplier; a skip sample goes to the gain bump. Input is
// accepted only while the sequencer is idle. Depends on twgt_pkg and twgt_div.
module twiddle_gain_tuner import twgt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // s_tdata: track_error [15:0], drive_action [31:16]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,
  // m_tdata: gain_0 [31:0], gain_1 [63:32], gain_2 [95:64],
  //          swept_index [97:96], phase [100:98], zero fill [103:101]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [31:0]  cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQ_E   = 4'd1;
  localparam logic [3:0] ST_SQ_A   = 4'd2;
  localparam logic [3:0] ST_ACC    = 4'd3;
  localparam logic [3:0] ST_DIV    = 4'd4;
  localparam logic [3:0] ST_DECIDE = 4'd5;
  localparam logic [3:0] ST_BUMP   = 4'd6;
  localparam logic [3:0] ST_SC_MUL = 4'd7;
  localparam logic [3:0] ST_SC_WR  = 4'd8;
  localparam logic [3:0] ST_OUT    = 4'd9;

  logic [3:0]         state;
  logic [1:0]         num_params;
  logic [WL_W-1:0]    window_length;
  logic [PHASE_W-1:0] phase_reg;
  logic [CNT_W-1:0]   sample_count;
  logic [SUM_W-1:0]   window_sum;
  logic [AVG_W-1:0]   best_average;
  logic [IDX_W-1:0]   sweep_pointer;
  logic [GAIN_W-1:0]  gain_store [MAX_GAINS];
  logic [STEP_W-1:0]  step_store [MAX_GAINS];
  logic signed [15:0] err_q, act_q;
  logic               grow;
  logic signed [PROD_W-1:0] prod;

  // combinational
  logic [WL_W-1:0]     eff_wl;
  logic [IDX_W-1:0]    eff_n;
  logic [IDX_W-1:0]    cur;
  logic [IDX_W:0]      ptr_inc;
  logic [IDX_W-1:0]    ptr_next;
  logic [CNT_W-1:0]    count_next;
  logic [SUM_W-1:0]    sum_next;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_q;
  logic [AVG_W-1:0]    avg;
  logic                win;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [GAIN_W-1:0]   cur_gain;
  logic [STEP_W-1:0]   cur_step;
  logic signed [GAIN_W+1:0] gain_plus;
  logic signed [GAIN_W+1:0] gain_minus2;
  logic [PROD_W-1:0]   rounded;
  logic [STEP_W-1:0]   scaled;
  logic                out_load;

  always_comb begin
    eff_wl = (window_length == '0) ? WL_W'(1) : window_length;
    if (num_params == 2'd0)
      eff_n = IDX_W'(1);
    else if (32'(num_params) > MAX_GAINS)
      eff_n = IDX_W'(MAX_GAINS);
    else
      eff_n = num_params;
    cur      = (32'(sweep_pointer) < MAX_GAINS) ? sweep_pointer : '0;
    ptr_inc  = {1'b0, sweep_pointer} + 1'b1;
    ptr_next = (ptr_inc >= {1'b0, eff_n}) ? '0 : ptr_inc[IDX_W-1:0];
    count_next = sample_count + 1'b1;
    sum_next   = window_sum + SUM_W'(prod[30:0]);
    div_start  = (state == ST_ACC) && (count_next > {1'b0, eff_wl});
    avg = div_q[AVG_W+7:8];
    win = avg < best_average;
    cur_gain = gain_store[cur];
    cur_step = step_store[cur];
    gain_plus   = $signed({{2{cur_gain[GAIN_W-1]}}, cur_gain})
                + $signed({3'b000, cur_step});
    gain_minus2 = $signed({{2{cur_gain[GAIN_W-1]}}, cur_gain})
                - $signed({2'b00, cur_step, 1'b0});
    // one shared multiplier: squares, then step rescale
    case (state)
      ST_SQ_E: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = MUL_B_W'(err_q);
      end
      ST_SQ_A: begin
        mul_a = MUL_A_W'(act_q);
        mul_b = MUL_B_W'(act_q);
      end
      default: begin
        mul_a = $signed({1'b0, cur_step});
        mul_b = grow ? GROW_Q16 : SHRINK_Q16;
      end
    endcase
    rounded = (PROD_W'(prod) + PROD_W'(32768)) >> 16;
    scaled  = (rounded > PROD_W'(STEP_MAX)) ? STEP_MAX : rounded[STEP_W-1:0];
    out_load = (state == ST_OUT) && (!m_tvalid || m_tready);
  end

  twgt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (eff_wl),
    .done     (div_done),
    .quotient (div_q)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      num_params    <= 2'd3;
      window_length <= WL_W'(100);
      phase_reg     <= PH_BASE;
      sample_count  <= '0;
      window_sum    <= '0;
      best_average  <= '0;
      sweep_pointer <= '1;
      m_tvalid      <= 1'b0;
      grow          <= 1'b0;
      for (int k = 0; k < MAX_GAINS; k++) begin
        gain_store[k] <= GAIN_RST;
        step_store[k] <= STEP_RST;
      end
    end else begin
      if (out_load)
        m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)
        m_tvalid <= 1'b0;
      if (state == ST_SQ_E || state == ST_SQ_A || state == ST_SC_MUL)
        prod <= mul_a * mul_b;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            err_q <= s_tdata[15:0];
            act_q <= s_tdata[31:16];
            if (phase_reg == PH_WSKIP || phase_reg == PH_RSKIP) begin
              // dropped sample: move on to the next gain
              sweep_pointer <= ptr_next;
              phase_reg     <= PH_PLUS;
              sample_count  <= '0;
              window_sum    <= '0;
              state         <= ST_BUMP;
            end else begin
              state <= ST_SQ_E;
            end
          end
        end
        ST_SQ_E: state <= ST_SQ_A;
        ST_SQ_A: begin
          window_sum <= sum_next;
          state      <= ST_ACC;
        end
        ST_ACC: begin
          window_sum   <= sum_next;
          sample_count <= count_next;
          state        <= div_start ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (div_done)
            state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          case (phase_reg)
            PH_PLUS, PH_MINUS: begin
              if (win) begin
                best_average <= avg;
                grow         <= 1'b1;
                phase_reg    <= PH_WSKIP;
                state        <= ST_SC_MUL;
              end else if (phase_reg == PH_PLUS) begin
                gain_store[cur] <= sat_gain(gain_minus2);
                phase_reg       <= PH_MINUS;
                sample_count    <= '0;
                window_sum      <= '0;
                state           <= ST_OUT;
              end else begin
                gain_store[cur] <= sat_gain(gain_plus);
                grow            <= 1'b0;
                phase_reg       <= PH_RSKIP;
                state           <= ST_SC_MUL;
              end
            end
            default: begin
              // first window sets the reference, sweep starts at gain 0
              best_average  <= avg;
              sweep_pointer <= '0;
              phase_reg     <= PH_PLUS;
              sample_count  <= '0;
              window_sum    <= '0;
              state         <= ST_BUMP;
            end
          endcase
        end
        ST_BUMP: begin
          gain_store[cur] <= sat_gain(gain_plus);
          state           <= ST_OUT;
        end
        ST_SC_MUL: state <= ST_SC_WR;
        ST_SC_WR: begin
          step_store[cur] <= scaled;
          state           <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            m_tdata  <= {3'b000, phase_reg,
                         (phase_reg == PH_BASE) ? {IDX_W{1'b0}} : cur,
                         gain_store[2], gain_store[1], gain_store[0]};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_idx)
          REG_NUM_PARAMS: num_params    <= cfg_data[1:0];
          REG_WIN_LEN:    window_length <= cfg_data[WL_W-1:0];
          REG_GAIN_0:     gain_store[0] <= cfg_data;
          REG_GAIN_1:     gain_store[1] <= cfg_data;
          REG_GAIN_2:     gain_store[2] <= cfg_data;
          REG_STEP_0:     step_store[0] <= cfg_data[STEP_W-1:0];
          REG_STEP_1:     step_store[1] <= cfg_data[STEP_W-1:0];
          REG_STEP_2:     step_store[2] <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
